[rtl/clut_texel_fetch_top_macros.svh]
// Assertion helpers shared by the texel fetch RTL.
// Each macro expects a clock named clk and an active-low reset named arst_n.
`ifndef CLUT_TEXEL_FETCH_TOP_MACROS_SVH
`define CLUT_TEXEL_FETCH_TOP_MACROS_SVH

// Same-cycle implication.
`define CTF_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define CTF_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/ctf_pkg.sv]
// ----------------------------------------------------------------------------
// ctf_pkg
// Shared constants, codes and types of the palettized texel fetch unit.
// ----------------------------------------------------------------------------
package ctf_pkg;

	// Video memory geometry; both sizes must be powers of two.
	localparam int MEM_COLS  = 1024;
	localparam int MEM_ROWS  = 512;
	localparam int COL_W     = $clog2(MEM_COLS);
	localparam int ROW_W     = $clog2(MEM_ROWS);
	localparam int ADDR_W    = COL_W + ROW_W;
	localparam int MEM_DEPTH = MEM_COLS * MEM_ROWS;

	// Fixed field widths.
	localparam int U_W        = 10;
	localparam int V_W        = 9;
	localparam int WORD_W     = 16;
	localparam int COLOR_W    = 8;
	localparam int IDX_W      = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;

	// Adder widths wide enough for base plus offset and for the memory size.
	localparam int SUMX_W = (COL_W > U_W + 1) ? COL_W : U_W + 1;
	localparam int SUMY_W = (ROW_W > V_W + 1) ? ROW_W : V_W + 1;

	// Queue geometry (both queues hold two entries).
	localparam int Q_DEPTH = 2;
	localparam int QPTR_W  = 1;
	localparam int QCNT_W  = 2;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_FETCH = 1'b1;

	localparam logic [1:0] DEPTH_IDX4   = 2'd0;
	localparam logic [1:0] DEPTH_IDX8   = 2'd1;
	localparam logic [1:0] DEPTH_DIRECT = 2'd2;
	localparam logic [1:0] DEPTH_NONE   = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_TEX_BASE_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TEX_BASE_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CLUT_X     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CLUT_Y     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TEX_DEPTH  = 3'd4;

	typedef enum logic [1:0] {
		CMD_WRITE  = 2'd0,
		CMD_DIRECT = 2'd1,
		CMD_IDX8   = 2'd2,
		CMD_IDX4   = 2'd3
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
		logic [WORD_W-1:0] data;
		logic [1:0]        sub;
	} cmd_t;

	typedef struct packed {
		logic [U_W-1:0] tex_base_x;
		logic [V_W-1:0] tex_base_y;
		logic [U_W-1:0] clut_x;
		logic [V_W-1:0] clut_y;
		logic [1:0]     tex_depth;
	} cfg_t;

	// Handshake between the command queue and the back end.
	typedef struct packed {
		logic empty;
		cmd_t head;
	} cmdq_status_t;

endpackage

[rtl/ctf_front.sv]
// ----------------------------------------------------------------------------
// ctf_front
// Accepts items, classifies them and computes the first memory address,
// then holds them in a two-entry command queue for the back end.
// ----------------------------------------------------------------------------
module ctf_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ctf_pkg::cfg_t                 cfg,
	input  logic                          push,
	output logic                          full,
	input  logic                          mode,
	input  logic [ctf_pkg::U_W-1:0]       col,
	input  logic [ctf_pkg::V_W-1:0]       row,
	input  logic [ctf_pkg::WORD_W-1:0]    word_in,
	output ctf_pkg::cmdq_status_t         cmdq,
	input  logic                          cmd_pop
);
	import ctf_pkg::*;

	logic [U_W-1:0]    base_x;
	logic [V_W-1:0]    base_y;
	logic [U_W-1:0]    u_off;
	logic [SUMX_W-1:0] sum_x;
	logic [SUMY_W-1:0] sum_y;
	cmd_t              cmd_new;
	logic              do_push;

	cmd_t              q_mem_q [Q_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	always_comb begin
		base_x = '0;
		base_y = '0;
		u_off  = col;
		cmd_new.kind = CMD_WRITE;
		cmd_new.sub  = col[1:0];
		cmd_new.data = word_in;
		if (mode == MODE_FETCH) begin
			base_x = cfg.tex_base_x;
			base_y = cfg.tex_base_y;
			case (cfg.tex_depth)
				DEPTH_DIRECT: begin
					cmd_new.kind = CMD_DIRECT;
				end
				DEPTH_IDX8: begin
					cmd_new.kind = CMD_IDX8;
					u_off = col >> 1;
					cmd_new.sub = {1'b0, col[0]};
				end
				default: begin
					cmd_new.kind = CMD_IDX4;
					u_off = col >> 2;
				end
			endcase
		end
		// Reduction modulo the memory size is a plain truncation.
		sum_x = SUMX_W'(base_x) + SUMX_W'(u_off);
		sum_y = SUMY_W'(base_y) + SUMY_W'(row);
		cmd_new.col = sum_x[COL_W-1:0];
		cmd_new.row = sum_y[ROW_W-1:0];
	end

	assign full    = (cnt_q == QCNT_W'(Q_DEPTH));
	assign do_push = push && !full;

	assign cmdq.empty = (cnt_q == '0);
	assign cmdq.head  = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			q_mem_q[wr_ptr_q] <= cmd_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (cmd_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, cmd_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[rtl/ctf_back.sv]
// ----------------------------------------------------------------------------
// ctf_back
// Owns the video memory and carries out queued commands: word writes,
// direct fetches and two-read palette fetches over the single memory port.
// ----------------------------------------------------------------------------
module ctf_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ctf_pkg::cfg_t              cfg,
	input  ctf_pkg::cmdq_status_t      cmdq,
	output logic                       cmd_pop,
	output logic                       res_push,
	output logic [ctf_pkg::WORD_W-1:0] res_word,
	input  logic                       res_full
);
	import ctf_pkg::*;
	`include "clut_texel_fetch_top_macros.svh"

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_TEX  = 3'b010,
		S_COL  = 3'b100
	} state_t;

	state_t            state_q;
	state_t            state_d;
	logic [WORD_W-1:0] vmem [MEM_DEPTH];
	logic [WORD_W-1:0] rdata_q;
	logic [1:0]        sub_q;
	logic              idx4_q;

	logic              can_take;
	logic              mem_we;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_addr;
	logic [IDX_W-1:0]  idx;
	logic [SUMX_W-1:0] pal_x;
	logic [SUMY_W-1:0] pal_y;

	// Palette index out of the texel word that was just read.
	always_comb begin
		if (idx4_q) begin
			case (sub_q)
				2'd0:    idx = {4'b0, rdata_q[3:0]};
				2'd1:    idx = {4'b0, rdata_q[7:4]};
				2'd2:    idx = {4'b0, rdata_q[11:8]};
				default: idx = {4'b0, rdata_q[15:12]};
			endcase
		end else begin
			idx = sub_q[0] ? rdata_q[15:8] : rdata_q[7:0];
		end
		pal_x = SUMX_W'(cfg.clut_x) + SUMX_W'(idx);
		pal_y = SUMY_W'(cfg.clut_y);
	end

	assign res_push = (state_q == S_COL) && !res_full;
	assign res_word = rdata_q;
	assign can_take = (state_q == S_IDLE) || res_push;
	assign cmd_pop  = can_take && !cmdq.empty;

	always_comb begin
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		mem_addr = {cmdq.head.row, cmdq.head.col};
		state_d  = state_q;
		if (state_q == S_TEX) begin
			mem_re   = 1'b1;
			mem_addr = {pal_y[ROW_W-1:0], pal_x[COL_W-1:0]};
			state_d  = S_COL;
		end else if (cmd_pop) begin
			case (cmdq.head.kind)
				CMD_WRITE: begin
					mem_we  = 1'b1;
					state_d = S_IDLE;
				end
				CMD_DIRECT: begin
					mem_re  = 1'b1;
					state_d = S_COL;
				end
				default: begin
					mem_re  = 1'b1;
					state_d = S_TEX;
				end
			endcase
		end else if (can_take) begin
			state_d = S_IDLE;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			vmem[mem_addr] <= cmdq.head.data;
		end
		if (mem_re) begin
			rdata_q <= vmem[mem_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			sub_q  <= cmdq.head.sub;
			idx4_q <= (cmdq.head.kind == CMD_IDX4);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`CTF_ASSERT_NXT(a_tex_then_col, state_q == S_TEX, state_q == S_COL, "texel read not followed by palette result")
	`CTF_ASSERT_NXT(a_stall_holds, (state_q == S_COL) && res_full, (state_q == S_COL) && $stable(rdata_q), "stalled result lost")
	`CTF_ASSERT_NXT(a_write_no_result, cmd_pop && (cmdq.head.kind == CMD_WRITE), state_q == S_IDLE, "write item produced a result")

endmodule

[rtl/ctf_outq.sv]
// ----------------------------------------------------------------------------
// ctf_outq
// Two-entry result queue; expands the 1-5-5-5 color word at its head.
// ----------------------------------------------------------------------------
module ctf_outq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        res_push,
	input  logic [ctf_pkg::WORD_W-1:0]  res_word,
	output logic                        res_full,
	output logic                        empty,
	input  logic                        pop,
	output logic [ctf_pkg::COLOR_W-1:0] red,
	output logic [ctf_pkg::COLOR_W-1:0] green,
	output logic [ctf_pkg::COLOR_W-1:0] blue,
	output logic [ctf_pkg::WORD_W-1:0]  raw_color
);
	import ctf_pkg::*;

	logic [WORD_W-1:0] q_mem_q [Q_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_pop;

	assign res_full = (cnt_q == QCNT_W'(Q_DEPTH));
	assign empty    = (cnt_q == '0);
	assign do_pop   = pop && !empty;

	assign raw_color = q_mem_q[rd_ptr_q];
	assign red       = {raw_color[4:0], 3'b000};
	assign green     = {raw_color[9:5], 3'b000};
	assign blue      = {raw_color[14:10], 3'b000};

	always_ff @(posedge clk) begin
		if (res_push) begin
			q_mem_q[wr_ptr_q] <= res_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (res_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({res_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[rtl/clut_texel_fetch_top.sv]
// ----------------------------------------------------------------------------
// clut_texel_fetch_top
// Palettized texel fetch unit over a 16-bit video memory.
// ----------------------------------------------------------------------------
// Usage: items enter on a queue-style port (push/full). A write item stores
// word_in at (col, row); a fetch item reads a texel at the texture base plus
// (col, row) in 4-bit, 8-bit or direct 16-bit depth. Each fetch produces one
// item on the result port (empty/pop) carrying the RGB expansion and the raw
// color word; writes produce nothing. Registers are set through cfg_wr_en,
// cfg_index and cfg_wdata; the user must set them only while the unit is
// idle, as the block itself does not enforce it.
// Timing: the single memory port sets the rate. A write uses the port once,
// a direct fetch one read and an indexed fetch two dependent reads (texel
// word, then palette entry); a new command is taken as a result is pushed.
// A fetch passes the command queue, the read register and the result queue.
// Reset clears the registers and both queues; memory contents are undefined
// until written. When the receiver stops popping, the result queue fills,
// the back end holds its last read, and full rises once the command queue
// holds two items.
module clut_texel_fetch_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [ctf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ctf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                            push,
	output logic                            full,
	input  logic                            mode,
	input  logic [ctf_pkg::U_W-1:0]         col,
	input  logic [ctf_pkg::V_W-1:0]         row,
	input  logic [ctf_pkg::WORD_W-1:0]      word_in,
	output logic                            empty,
	input  logic                            pop,
	output logic [ctf_pkg::COLOR_W-1:0]     red,
	output logic [ctf_pkg::COLOR_W-1:0]     green,
	output logic [ctf_pkg::COLOR_W-1:0]     blue,
	output logic [ctf_pkg::WORD_W-1:0]      raw_color
);
	import ctf_pkg::*;

	cfg_t              cfg_q;
	cmdq_status_t      cmdq;
	logic              cmd_pop;
	logic              res_push;
	logic              res_full;
	logic [WORD_W-1:0] res_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_TEX_BASE_X: cfg_q.tex_base_x <= cfg_wdata[U_W-1:0];
				REG_TEX_BASE_Y: cfg_q.tex_base_y <= cfg_wdata[V_W-1:0];
				REG_CLUT_X:     cfg_q.clut_x     <= cfg_wdata[U_W-1:0];
				REG_CLUT_Y:     cfg_q.clut_y     <= cfg_wdata[V_W-1:0];
				REG_TEX_DEPTH: begin
					// The undefined depth code leaves the mode unchanged.
					if (cfg_wdata[1:0] != DEPTH_NONE) begin
						cfg_q.tex_depth <= cfg_wdata[1:0];
					end
				end
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	ctf_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.push    (push),
		.full    (full),
		.mode    (mode),
		.col     (col),
		.row     (row),
		.word_in (word_in),
		.cmdq    (cmdq),
		.cmd_pop (cmd_pop)
	);

	ctf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cmdq     (cmdq),
		.cmd_pop  (cmd_pop),
		.res_push (res_push),
		.res_word (res_word),
		.res_full (res_full)
	);

	ctf_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_push  (res_push),
		.res_word  (res_word),
		.res_full  (res_full),
		.empty     (empty),
		.pop       (pop),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.raw_color (raw_color)
	);

endmodule

[tb/sv/clut_texel_fetch_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// clut_texel_fetch_top_tb
// Self-checking bench for the palettized texel fetch unit. Write and fetch
// items go in through the push/full port while a shadow of video memory and
// of the registers predicts the color of every fetch. Fetch results are
// popped with random stalls and compared field by field in order. Fetches
// only touch words that were written before.
// ----------------------------------------------------------------------------
module clut_texel_fetch_top_tb;
	import ctf_pkg::*;

	localparam int IDLE_SETTLE = 12;
	localparam int TIMEOUT_NS  = 5_000_000;
	localparam int SEGMENTS    = 6;

	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
		logic [WORD_W-1:0]  raw;
	} rgb_item_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  push = 1'b0;
	logic                  full;
	logic                  mode = MODE_WRITE;
	logic [U_W-1:0]        col = '0;
	logic [V_W-1:0]        row = '0;
	logic [WORD_W-1:0]     word_in = '0;
	logic                  empty;
	logic                  pop = 1'b0;
	logic [COLOR_W-1:0]    red;
	logic [COLOR_W-1:0]    green;
	logic [COLOR_W-1:0]    blue;
	logic [WORD_W-1:0]     raw_color;

	// Shadow of the block: written memory words and the register values.
	logic [WORD_W-1:0] vram_words [int];
	logic [U_W-1:0]    tex_org_x = '0;
	logic [V_W-1:0]    tex_org_y = '0;
	logic [U_W-1:0]    pal_col = '0;
	logic [V_W-1:0]    pal_row = '0;
	logic [1:0]        tex_mode = DEPTH_IDX4;

	rgb_item_t pending_colors [$];
	int        failures = 0;
	int        items_sent = 0;
	int        push_gap_pct = 38;
	int        pop_stall_pct = 57;
	logic [1:0] depth_cycle [3] = '{DEPTH_IDX4, DEPTH_IDX8, DEPTH_DIRECT};

	clut_texel_fetch_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.push      (push),
		.full      (full),
		.mode      (mode),
		.col       (col),
		.row       (row),
		.word_in   (word_in),
		.empty     (empty),
		.pop       (pop),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.raw_color (raw_color)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic int flat_addr(input int x, input int y);
		return (y % MEM_ROWS) * MEM_COLS + (x % MEM_COLS);
	endfunction

	// Address of the memory word that holds texel (u, v) at the current depth.
	function automatic int texel_addr(input logic [U_W-1:0] u, input logic [V_W-1:0] v);
		int x;
		case (tex_mode)
			DEPTH_DIRECT: x = int'(tex_org_x) + int'(u);
			DEPTH_IDX8:   x = int'(tex_org_x) + int'(u >> 1);
			default:      x = int'(tex_org_x) + int'(u >> 2);
		endcase
		return flat_addr(x, int'(tex_org_y) + int'(v));
	endfunction

	function automatic int palette_addr(input logic [U_W-1:0] u, input logic [V_W-1:0] v);
		logic [WORD_W-1:0] t;
		int idx;
		t = vram_words[texel_addr(u, v)];
		if (tex_mode == DEPTH_IDX8)
			idx = int'(t[8 * u[0] +: 8]);
		else
			idx = int'(t[4 * u[1:0] +: 4]);
		return flat_addr(int'(pal_col) + idx, int'(pal_row));
	endfunction

	function automatic rgb_item_t predict_fetch(input logic [U_W-1:0] u,
			input logic [V_W-1:0] v);
		logic [WORD_W-1:0] c;
		rgb_item_t e;
		if (tex_mode == DEPTH_DIRECT)
			c = vram_words[texel_addr(u, v)];
		else
			c = vram_words[palette_addr(u, v)];
		e.red   = {c[4:0], 3'b000};
		e.green = {c[9:5], 3'b000};
		e.blue  = {c[14:10], 3'b000};
		e.raw   = c;
		return e;
	endfunction

	// Push stays high after acceptance; in the same time step the next call lowers
	// it or drives a new item, or the caller lowers it, so no item is taken twice.
	task automatic send_item(input logic m, input logic [U_W-1:0] c,
			input logic [V_W-1:0] r, input logic [WORD_W-1:0] w);
		while ($urandom_range(99) < push_gap_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push    <= 1'b1;
		mode    <= m;
		col     <= c;
		row     <= r;
		word_in <= w;
		do @(posedge clk); while (full);
		items_sent++;
		if (m == MODE_WRITE)
			vram_words[flat_addr(int'(c), int'(r))] = w;
		else
			pending_colors.push_back(predict_fetch(c, r));
	endtask

	task automatic write_word_at(input int a);
		send_item(MODE_WRITE, U_W'(a % MEM_COLS), V_W'(a / MEM_COLS), WORD_W'($urandom));
	endtask

	// Writes the texel word and the palette entry first where they are missing.
	task automatic fetch_texel(input logic [U_W-1:0] u, input logic [V_W-1:0] v);
		if (!vram_words.exists(texel_addr(u, v)))
			write_word_at(texel_addr(u, v));
		if (tex_mode != DEPTH_DIRECT && !vram_words.exists(palette_addr(u, v)))
			write_word_at(palette_addr(u, v));
		send_item(MODE_FETCH, u, v, WORD_W'($urandom));
	endtask

	task automatic wait_idle();
		push <= 1'b0;
		while (pending_colors.size() != 0)
			@(posedge clk);
		repeat (IDLE_SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_TEX_BASE_X: tex_org_x = val[U_W-1:0];
			REG_TEX_BASE_Y: tex_org_y = val[V_W-1:0];
			REG_CLUT_X:     pal_col = val[U_W-1:0];
			REG_CLUT_Y:     pal_row = val[V_W-1:0];
			REG_TEX_DEPTH:  if (val[1:0] != DEPTH_NONE) tex_mode = val[1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic check_field(input string fname, input logic [WORD_W-1:0] want,
			input logic [WORD_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
			failures++;
		end
	endtask

	task automatic compare_color();
		rgb_item_t e;
		if (pending_colors.size() == 0) begin
			$error("raw_color: expected no item, got 0x%0h", raw_color);
			failures++;
			return;
		end
		e = pending_colors.pop_front();
		check_field("red", WORD_W'(e.red), WORD_W'(red));
		check_field("green", WORD_W'(e.green), WORD_W'(green));
		check_field("blue", WORD_W'(e.blue), WORD_W'(blue));
		check_field("raw_color", e.raw, raw_color);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty)
				compare_color();
			pop <= ($urandom_range(99) >= pop_stall_pct);
		end
	end

	// Registers still at reset: 4-bit texels at the origin, palette at the origin.
	// The palette entry for index zero is the texel word itself.
	task automatic test_reset_defaults();
		send_item(MODE_WRITE, 0, 0, 16'hF5A0);
		send_item(MODE_WRITE, 10, 0, 16'hFFFF);
		send_item(MODE_WRITE, 5, 0, 16'h8000);
		send_item(MODE_WRITE, 15, 0, 16'h7FFF);
		for (int u = 0; u < 4; u++)
			fetch_texel(U_W'(u), 0);
	endtask

	task automatic test_direct_wrap();
		wait_idle();
		write_reg(REG_TEX_BASE_X, '1);
		write_reg(REG_TEX_BASE_Y, '1);
		write_reg(REG_TEX_DEPTH, {{(CFG_DATA_W - 2){1'b0}}, DEPTH_DIRECT});
		send_item(MODE_WRITE, 1022, 510, 16'h001F);
		send_item(MODE_WRITE, 1023, 511, 16'h7C00);
		fetch_texel('1, '1);
		fetch_texel(0, 0);
		fetch_texel(1, 1);
	endtask

	// The high palette index runs past the last column and wraps.
	task automatic test_indexed8_palette_wrap();
		wait_idle();
		write_reg(REG_CLUT_X, 1000);
		write_reg(REG_CLUT_Y, '1);
		write_reg(REG_TEX_DEPTH, {{(CFG_DATA_W - 2){1'b1}}, DEPTH_IDX8});
		send_item(MODE_WRITE, 1023, 0, 16'hFF00);
		send_item(MODE_WRITE, 1000, 511, 16'h03E0);
		send_item(MODE_WRITE, 231, 511, 16'h5555);
		fetch_texel(0, 1);
		fetch_texel(1, 1);
	endtask

	task automatic test_ignored_config();
		wait_idle();
		write_reg(REG_TEX_DEPTH, {{(CFG_DATA_W - 2){1'b0}}, DEPTH_NONE});
		for (int i = REG_TEX_DEPTH + 1; i < 2 ** CFG_IDX_W; i++)
			write_reg(CFG_IDX_W'(i), '1);
		write_reg(REG_TEX_BASE_Y, '1);
		fetch_texel(1, 1);
	endtask

	task automatic apply_settings(input int seg);
		logic [CFG_DATA_W-1:0] vals [4];
		logic [CFG_DATA_W-1:0] dv;
		wait_idle();
		for (int i = 0; i < 4; i++) begin
			case (seg % 4)
				0:       vals[i] = '0;
				1:       vals[i] = '1;
				default: vals[i] = CFG_DATA_W'($urandom);
			endcase
		end
		write_reg(REG_TEX_BASE_X, vals[0]);
		write_reg(REG_TEX_BASE_Y, vals[1]);
		write_reg(REG_CLUT_X, vals[2]);
		write_reg(REG_CLUT_Y, vals[3]);
		dv = CFG_DATA_W'($urandom);
		dv[1:0] = depth_cycle[seg % 3];
		write_reg(REG_TEX_DEPTH, dv);
		if ($urandom_range(2) == 0) begin
			dv[1:0] = DEPTH_NONE;
			write_reg(REG_TEX_DEPTH, dv);
		end
	endtask

	// Mostly fetches, some near the origin so texels and palettes get reused,
	// and plain writes anywhere as noise.
	task automatic random_item();
		int pick;
		pick = $urandom_range(99);
		if (pick < 25)
			send_item(MODE_WRITE, U_W'($urandom), V_W'($urandom), WORD_W'($urandom));
		else if (pick < 45)
			fetch_texel(U_W'($urandom_range(31)), V_W'($urandom_range(3)));
		else
			fetch_texel(U_W'($urandom), V_W'($urandom));
	endtask

	task automatic test_random_traffic(input int phase, input int gap_pct,
			input int stall_pct, input int count);
		int seg_goal;
		push_gap_pct = gap_pct;
		pop_stall_pct = stall_pct;
		for (int s = 0; s < SEGMENTS; s++) begin
			apply_settings(phase * SEGMENTS + s);
			seg_goal = items_sent + count / SEGMENTS;
			while (items_sent < seg_goal)
				random_item();
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_direct_wrap();
		test_indexed8_palette_wrap();
		test_ignored_config();
		test_random_traffic(0, 38, 57, 450);
		test_random_traffic(1, 57, 38, 450);
		test_random_traffic(2, 0, 0, 450);
		wait_idle();
		if (failures == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("TEST FAILED");
		$finish;
	end

endmodule
